// File: hw/rtl/wpsd_pkg.sv
// Shared types and constants of the wheel PI speed drive.
package wpsd_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 23;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_INTEG_LIMIT  = 3'd2,
    REG_DRIVE_LIMIT  = 3'd3,
    REG_DEAD_BAND    = 3'd4,
    REG_TRIM_WHEEL_A = 3'd5,
    REG_TRIM_WHEEL_B = 3'd6,
    REG_TRIM_WHEEL_C = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIR_COAST   = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_e;

  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [15:0] PROP_GAIN_RST   = 16'd256;
  localparam logic [15:0] INTEG_GAIN_RST  = 16'd0;
  localparam logic [22:0] INTEG_LIMIT_RST = 23'd25600;
  localparam logic [9:0]  DRIVE_LIMIT_RST = 10'd1023;
  localparam logic [9:0]  DEAD_BAND_RST   = 10'd0;
  localparam logic [8:0]  TRIM_UNITY      = 9'd256;

  localparam logic signed [15:0] TARGET_NEAR_ZERO = 16'sd26;
  localparam logic signed [16:0] ERR_NEAR_ZERO    = 17'sd52;

endpackage

// File: hw/rtl/wheel_pi_speed_drive.sv
// Per-wheel PI speed controller with anti-windup, trim, dead band and drive clamp.
//
// The input channel carries one beat per control step: a command, a wheel index
// and the target and measured speeds in signed Q7.8. The output channel returns
// one beat per input beat: the echoed wheel, the duty magnitude, the direction
// and the signed drive. Configuration registers are written through a plain
// write port and should only change while the block is idle.
// A control step runs through a small sequencer that shares one 25 x 17 bit
// multiplier for the proportional term, the integral term and the trim. Its
// steps are integrate, multiply P, multiply I, scale, multiply trim, shift and
// output, and a new input beat is taken only once the previous step is done.
// A clear command or a wheel index with no controller skips to the output step.
// The block holds the input stall high while a step is in progress and takes
// the next beat as soon as the sequencer is back at rest, even while a result
// is still waiting in the output register. When the receiver stalls, the
// finished step waits in its last stage until the output register is free.
// Reset clears every integral, loads the configuration reset values and
// empties the output register.
module wheel_pi_speed_drive #(
  parameter int WHEEL_COUNT = 3,
  parameter int DUTY_BITS   = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [1:0]                        wheel_index_i,
  input  logic signed [15:0]                target_speed_i,
  input  logic signed [15:0]                measured_speed_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        wheel_out_o,
  output logic [DUTY_BITS-1:0]              duty_o,
  output logic [1:0]                        direction_o,
  output logic signed [10:0]                signed_drive_o,
  input  logic                              cfg_we_i,
  input  logic [wpsd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [wpsd_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int          WIdxW   = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
  localparam logic [16:0] MaxDuty = 17'((1 << DUTY_BITS) - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INTEG, S_MULP, S_MULI, S_PWM, S_MULT, S_SHIFT, S_OUT
  } state_e;

  state_e                 state_q;
  logic [15:0]            prop_gain_q, integ_gain_q;
  logic [22:0]            integ_limit_q;
  logic [9:0]             drive_limit_q, dead_band_q;
  logic [8:0]             trim_q [3];
  logic signed [23:0]     integ_store_q [WHEEL_COUNT];

  logic [1:0]             wheel_q;
  logic signed [16:0]     err_q;
  logic                   tnear_q;
  logic signed [23:0]     integ_q;
  logic signed [41:0]     acc_q;
  logic signed [24:0]     pwm_q;
  logic [25:0]            mag_q;
  logic                   neg_q;

  logic                   out_valid_q;
  logic [1:0]             wheel_out_q;
  logic [DUTY_BITS-1:0]   duty_q;
  wpsd_pkg::dir_e         dir_q;
  logic signed [10:0]     drive_q;

  logic [WIdxW-1:0]       widx;
  logic signed [24:0]     isum, ilim, iclamp;
  logic                   enear;
  logic signed [23:0]     inext;
  logic signed [24:0]     mul_a;
  logic [15:0]            mul_b;
  logic signed [41:0]     prod;
  logic [8:0]             trim_sel;
  logic signed [41:0]     t16, t8;
  logic signed [25:0]     v8;
  logic [25:0]            mag8;
  logic [9:0]             lim10, fmag;
  logic signed [10:0]     sdrive;
  wpsd_pkg::dir_e         dir_d;
  logic                   accept, out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    widx   = WIdxW'(wheel_q);
    isum   = $signed({integ_store_q[widx][23], integ_store_q[widx]})
           + $signed({{8{err_q[16]}}, err_q});
    ilim   = $signed({2'b00, integ_limit_q});
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
    enear = (err_q > -wpsd_pkg::ERR_NEAR_ZERO) && (err_q < wpsd_pkg::ERR_NEAR_ZERO);
    inext = (tnear_q && enear) ? 24'sd0 : iclamp[23:0];

    case (wheel_q)
      2'd0:    trim_sel = trim_q[0];
      2'd1:    trim_sel = trim_q[1];
      2'd2:    trim_sel = trim_q[2];
      default: trim_sel = wpsd_pkg::TRIM_UNITY;
    endcase

    case (state_q)
      S_MULI: begin
        mul_a = $signed({integ_q[23], integ_q});
        mul_b = integ_gain_q;
      end
      S_MULT: begin
        mul_a = pwm_q;
        mul_b = {7'b0, trim_sel};
      end
      default: begin
        mul_a = $signed({{8{err_q[16]}}, err_q});
        mul_b = prop_gain_q;
      end
    endcase
    prod = mul_a * $signed({1'b0, mul_b});

    t16  = acc_q + (acc_q[41] ? 42'sd65535 : 42'sd0);
    t8   = acc_q + (acc_q[41] ? 42'sd255 : 42'sd0);
    v8   = t8[33:8];
    mag8 = v8[25] ? 26'(-v8) : 26'(v8);

    lim10 = ({7'b0, drive_limit_q} > MaxDuty) ? MaxDuty[9:0] : drive_limit_q;
    if (mag_q < {16'b0, dead_band_q}) begin
      fmag = 10'd0;
    end else if (mag_q > {16'b0, lim10}) begin
      fmag = lim10;
    end else begin
      fmag = mag_q[9:0];
    end
    sdrive = neg_q ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
    if (fmag == 10'd0) begin
      dir_d = wpsd_pkg::DIR_COAST;
    end else if (neg_q) begin
      dir_d = wpsd_pkg::DIR_REVERSE;
    end else begin
      dir_d = wpsd_pkg::DIR_FORWARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      prop_gain_q   <= wpsd_pkg::PROP_GAIN_RST;
      integ_gain_q  <= wpsd_pkg::INTEG_GAIN_RST;
      integ_limit_q <= wpsd_pkg::INTEG_LIMIT_RST;
      drive_limit_q <= wpsd_pkg::DRIVE_LIMIT_RST;
      dead_band_q   <= wpsd_pkg::DEAD_BAND_RST;
      for (int i = 0; i < 3; i++) begin
        trim_q[i] <= wpsd_pkg::TRIM_UNITY;
      end
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        integ_store_q[i] <= 24'sd0;
      end
      wheel_q     <= 2'd0;
      err_q       <= 17'sd0;
      tnear_q     <= 1'b0;
      integ_q     <= 24'sd0;
      acc_q       <= 42'sd0;
      pwm_q       <= 25'sd0;
      mag_q       <= 26'd0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      wheel_out_q <= 2'd0;
      duty_q      <= '0;
      dir_q       <= wpsd_pkg::DIR_COAST;
      drive_q     <= 11'sd0;
    end else begin
      if (cfg_we_i) begin
        unique case (wpsd_pkg::cfg_reg_e'(cfg_index_i))
          wpsd_pkg::REG_PROP_GAIN:    prop_gain_q   <= cfg_data_i[15:0];
          wpsd_pkg::REG_INTEG_GAIN:   integ_gain_q  <= cfg_data_i[15:0];
          wpsd_pkg::REG_INTEG_LIMIT:  integ_limit_q <= cfg_data_i[22:0];
          wpsd_pkg::REG_DRIVE_LIMIT:  drive_limit_q <= cfg_data_i[9:0];
          wpsd_pkg::REG_DEAD_BAND:    dead_band_q   <= cfg_data_i[9:0];
          wpsd_pkg::REG_TRIM_WHEEL_A: trim_q[0]     <= cfg_data_i[8:0];
          wpsd_pkg::REG_TRIM_WHEEL_B: trim_q[1]     <= cfg_data_i[8:0];
          wpsd_pkg::REG_TRIM_WHEEL_C: trim_q[2]     <= cfg_data_i[8:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            wheel_q <= wheel_index_i;
            err_q   <= $signed({target_speed_i[15], target_speed_i})
                     - $signed({measured_speed_i[15], measured_speed_i});
            tnear_q <= (target_speed_i > -wpsd_pkg::TARGET_NEAR_ZERO)
                    && (target_speed_i < wpsd_pkg::TARGET_NEAR_ZERO);
            mag_q   <= 26'd0;
            neg_q   <= 1'b0;
            if (command_i == wpsd_pkg::CMD_CLEAR) begin
              for (int i = 0; i < WHEEL_COUNT; i++) begin
                integ_store_q[i] <= 24'sd0;
              end
              state_q <= S_OUT;
            end else if ({2'b00, wheel_index_i} >= 4'(WHEEL_COUNT)) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_INTEG;
            end
          end
        end
        S_INTEG: begin
          integ_store_q[widx] <= inext;
          integ_q             <= inext;
          state_q             <= S_MULP;
        end
        S_MULP: begin
          acc_q   <= prod;
          state_q <= S_MULI;
        end
        S_MULI: begin
          acc_q   <= acc_q + prod;
          state_q <= S_PWM;
        end
        S_PWM: begin
          pwm_q   <= t16[40:16];
          state_q <= S_MULT;
        end
        S_MULT: begin
          acc_q   <= prod;
          state_q <= S_SHIFT;
        end
        S_SHIFT: begin
          mag_q   <= mag8;
          neg_q   <= v8[25];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            wheel_out_q <= wheel_q;
            duty_q      <= DUTY_BITS'(fmag);
            dir_q       <= dir_d;
            drive_q     <= sdrive;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign wheel_out_o    = wheel_out_q;
  assign duty_o         = duty_q;
  assign direction_o    = dir_q;
  assign signed_drive_o = drive_q;

endmodule

// File: verif/tb_wheel_pi_speed_drive.sv
// Self-checking testbench for wheel_pi_speed_drive: directed and random control steps.
module tb_wheel_pi_speed_drive;
  timeunit 1ns;
  timeprecision 1ps;

  import wpsd_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 6;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 100;
  localparam int HOLD_AT       = 171;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 16;

  typedef struct packed {
    logic [1:0]         wheel;
    logic [9:0]         duty;
    dir_e               dir;
    logic signed [10:0] drive;
  } drive_t;

  typedef struct {
    bit                 is_reg;
    cfg_reg_e           idx;
    logic [22:0]        val;
    logic               cmd;
    logic [1:0]         wh;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    bit                 known;
    drive_t             want;
  } row_t;

  logic                       clk_i            = 1'b0;
  logic                       rst_ni           = 1'b0;
  logic                       in_valid_i       = 1'b0;
  logic                       in_stall_o;
  logic                       command_i        = 1'b0;
  logic [1:0]                 wheel_index_i    = '0;
  logic signed [15:0]         target_speed_i   = '0;
  logic signed [15:0]         measured_speed_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i      = 1'b0;
  logic [1:0]                 wheel_out_o;
  logic [9:0]                 duty_o;
  logic [1:0]                 direction_o;
  logic signed [10:0]         signed_drive_o;
  logic                       cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index_i      = '0;
  logic [CfgDataW-1:0]        cfg_data_i       = '0;

  logic [15:0]        prop_gain;
  logic [15:0]        integ_gain;
  logic [22:0]        integ_limit;
  logic [9:0]         drive_limit;
  logic [9:0]         dead_band;
  logic [8:0]         trim_gain [3];
  logic signed [23:0] integ_acc [3];

  drive_t drive_queue [$];
  row_t   plan [$];

  bit gaps_on       = 1'b1;
  int items_in      = 0;
  int results_seen  = 0;
  int errors        = 0;
  int n_steps       = 0;
  int n_clears      = 0;
  int n_spare       = 0;
  int settings_used = 1;

  wheel_pi_speed_drive DUT (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic drive_t pi_drive_step(input logic cmd, input logic [1:0] wh,
                                           input logic signed [15:0] tgt,
                                           input logic signed [15:0] meas);
    drive_t r;
    longint t, err, acc, lim, raw, pwm, mag;
    r.wheel = wh;
    r.duty  = '0;
    r.dir   = DIR_COAST;
    r.drive = '0;
    if (cmd == CMD_CLEAR) begin
      foreach (integ_acc[i]) integ_acc[i] = '0;
      return r;
    end
    if (wh > 2'd2) return r;
    t   = longint'(tgt);
    err = t - longint'(meas);
    lim = longint'(integ_limit);
    acc = longint'(integ_acc[wh]) + err;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    if (t > -longint'(TARGET_NEAR_ZERO) && t < longint'(TARGET_NEAR_ZERO) &&
        err > -longint'(ERR_NEAR_ZERO) && err < longint'(ERR_NEAR_ZERO)) begin
      acc = 0;
    end
    integ_acc[wh] = acc[23:0];
    raw = longint'(prop_gain) * err + longint'(integ_gain) * acc;
    pwm = raw / 65536;
    pwm = (pwm * longint'(trim_gain[wh])) / 256;
    if (pwm != 0) begin
      if (pwm < longint'(dead_band) && pwm > -longint'(dead_band)) pwm = 0;
      lim = longint'(drive_limit);
      if (pwm > lim) pwm = lim;
      if (pwm < -lim) pwm = -lim;
    end
    mag     = pwm < 0 ? -pwm : pwm;
    r.duty  = mag[9:0];
    r.drive = pwm[10:0];
    if (pwm > 0) r.dir = DIR_FORWARD;
    else if (pwm < 0) r.dir = DIR_REVERSE;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic void add_reg(input cfg_reg_e idx, input logic [22:0] val);
    row_t r;
    r        = '{idx: REG_PROP_GAIN, default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    plan.push_back(r);
  endfunction

  function automatic void add_step(input logic cmd, input logic [1:0] wh,
                                   input logic signed [15:0] tgt,
                                   input logic signed [15:0] meas);
    row_t r;
    r      = '{idx: REG_PROP_GAIN, default: '0};
    r.cmd  = cmd;
    r.wh   = wh;
    r.tgt  = tgt;
    r.meas = meas;
    plan.push_back(r);
  endfunction

  function automatic void add_known(input logic cmd, input logic [1:0] wh,
                                    input logic signed [15:0] tgt,
                                    input logic signed [15:0] meas, input logic [9:0] duty,
                                    input dir_e dir, input logic signed [10:0] drive);
    row_t r;
    r       = '{idx: REG_PROP_GAIN, default: '0};
    r.cmd   = cmd;
    r.wh    = wh;
    r.tgt   = tgt;
    r.meas  = meas;
    r.known = 1'b1;
    r.want  = '{wheel: wh, duty: duty, dir: dir, drive: drive};
    plan.push_back(r);
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [22:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PROP_GAIN:    prop_gain    = val[15:0];
      REG_INTEG_GAIN:   integ_gain   = val[15:0];
      REG_INTEG_LIMIT:  integ_limit  = val[22:0];
      REG_DRIVE_LIMIT:  drive_limit  = val[9:0];
      REG_DEAD_BAND:    dead_band    = val[9:0];
      REG_TRIM_WHEEL_A: trim_gain[0] = val[8:0];
      REG_TRIM_WHEEL_B: trim_gain[1] = val[8:0];
      REG_TRIM_WHEEL_C: trim_gain[2] = val[8:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The beat is held until the block takes it; the prediction is made at that edge.
  task automatic send_beat(input logic cmd, input logic [1:0] wh,
                           input logic signed [15:0] tgt, input logic signed [15:0] meas,
                           input bit known, input drive_t want);
    drive_t pred;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    wheel_index_i    <= wh;
    target_speed_i   <= tgt;
    measured_speed_i <= meas;
    do @(posedge clk_i); while (in_stall_o);
    pred = pi_drive_step(cmd, wh, tgt, meas);
    drive_queue.push_back(known ? want : pred);
    items_in++;
    if (cmd == CMD_CLEAR) n_clears++;
    else if (wh > 2'd2) n_spare++;
    else n_steps++;
  endtask

  initial begin : stimulus
    logic [22:0]        setting [8];
    logic               cmd;
    logic [1:0]         wh;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    int                 kind;
    prop_gain    = PROP_GAIN_RST;
    integ_gain   = INTEG_GAIN_RST;
    integ_limit  = INTEG_LIMIT_RST;
    drive_limit  = DRIVE_LIMIT_RST;
    dead_band    = DEAD_BAND_RST;
    foreach (trim_gain[i]) trim_gain[i] = TRIM_UNITY;
    foreach (integ_acc[i]) integ_acc[i] = '0;

    add_known(1'b0, 2'd0, 16'sh7FFF, -16'sh8000, 10'd255, DIR_FORWARD, 11'sd255);
    add_known(1'b0, 2'd1, -16'sh8000, 16'sh7FFF, 10'd255, DIR_REVERSE, -11'sd255);
    add_known(1'b0, 2'd2, 16'sd0, 16'sd0, 10'd0, DIR_COAST, 11'sd0);
    add_known(1'b0, 2'd3, 16'sd1000, 16'sd0, 10'd0, DIR_COAST, 11'sd0);
    add_known(CMD_CLEAR, 2'd1, 16'sh7FFF, -16'sh8000, 10'd0, DIR_COAST, 11'sd0);
    add_known(CMD_CLEAR, 2'd3, -16'sd1, -16'sd1, 10'd0, DIR_COAST, 11'sd0);
    add_known(1'b0, 2'd0, 16'sd25, -16'sd26, 10'd0, DIR_COAST, 11'sd0);
    add_known(1'b0, 2'd0, 16'sd26, 16'sd0, 10'd0, DIR_COAST, 11'sd0);
    add_known(1'b0, 2'd1, -16'sd256, 16'sd0, 10'd1, DIR_REVERSE, -11'sd1);
    add_known(1'b0, 2'd2, -16'sd255, 16'sd0, 10'd0, DIR_COAST, 11'sd0);
    add_reg(REG_INTEG_GAIN, 23'd256);
    add_step(1'b0, 2'd0, 16'sh7FFF, 16'sd0);
    add_step(1'b0, 2'd0, 16'sh7FFF, 16'sd0);
    add_step(1'b0, 2'd0, 16'sh7FFF, 16'sd0);
    add_step(1'b0, 2'd0, 16'sd10, 16'sd5);
    add_reg(REG_DEAD_BAND, 23'd100);
    add_reg(REG_TRIM_WHEEL_A, 23'd511);
    add_reg(REG_TRIM_WHEEL_B, 23'd0);
    add_reg(REG_TRIM_WHEEL_C, 23'd128);
    add_reg(REG_DRIVE_LIMIT, 23'd500);
    add_reg(REG_INTEG_LIMIT, 23'h7FFFFF);
    add_step(1'b0, 2'd0, 16'sd10000, 16'sd0);
    add_step(1'b0, 2'd1, 16'sd10000, 16'sd0);
    add_step(1'b0, 2'd2, -16'sh8000, 16'sh7FFF);
    add_step(1'b0, 2'd0, 16'sd20, 16'sd0);
    add_step(1'b0, 2'd2, 16'sd30000, 16'sd29000);
    add_step(CMD_CLEAR, 2'd0, 16'sd0, 16'sd0);
    add_step(1'b0, 2'd0, 16'sd5000, 16'sd5000);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_beat(plan[i].cmd, plan[i].wh, plan[i].tgt, plan[i].meas, plan[i].known,
                  plan[i].want);
      end
    end
    settings_used++;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: setting = '{$urandom_range(128, 1024), $urandom_range(0, 64),
                       $urandom_range(256, 40000), 1023, $urandom_range(0, 20),
                       $urandom_range(200, 300), $urandom_range(200, 300),
                       $urandom_range(200, 300)};
        1: setting = '{65535, 65535, 23'h7FFFFF, 1023, 1023, 511, 511, 511};
        2: setting = '{65535, 65535, 0, 1, 0, 511, 0, 1};
        3: setting = '{0, 1, 23'h7FFFFF, 1023, 0, 256, 256, 256};
        4: foreach (setting[r]) setting[r] = $urandom_range(0, 23'h7FFFFF);
        default: setting = '{$urandom_range(0, 4095), $urandom_range(0, 255),
                             $urandom_range(0, 200000), $urandom_range(0, 1023),
                             $urandom_range(0, 50), $urandom_range(0, 511),
                             $urandom_range(0, 511), $urandom_range(0, 511)};
      endcase
      for (int r = 0; r < 8; r++) write_reg(cfg_reg_e'(r), setting[r]);
      settings_used++;
      gaps_on = (ph != PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 99);
        cmd  = 1'b0;
        wh   = 2'($urandom_range(0, 2));
        {tgt, meas} = $urandom();
        if (kind < 5) begin
          cmd = CMD_CLEAR;
          wh  = 2'($urandom_range(0, 3));
        end else if (kind < 10) begin
          wh = 2'd3;
        end else if (kind < 25) begin
          tgt  = $urandom_range(0, 60) - 30;
          meas = tgt + $urandom_range(0, 120) - 60;
        end else if (kind >= 45) begin
          tgt  = $urandom_range(0, 16000) - 8000;
          meas = tgt + $urandom_range(0, 2000) - 1000;
        end
        send_beat(cmd, wh, tgt, meas, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d beats: %0d control steps, %0d clear commands, %0d unused-wheel steps.",
             items_in, n_steps, n_clears, n_spare);
    $display("Checked %0d results across %0d register settings.", results_seen,
             settings_used);
    if (errors == 0) begin
      $display("tb_wheel_pi_speed_drive: clean");
    end else begin
      $display("tb_wheel_pi_speed_drive: errors");
    end
    $finish;
  end

  initial begin : result_side
    int     stall_left;
    bit     held;
    drive_t want;
    stall_left = 0;
    held       = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (drive_queue.size() == 0) begin
          errors++;
          $display("%0t ns: result beat for wheel %0d with nothing expected", $time,
                   wheel_out_o);
        end else begin
          want = drive_queue.pop_front();
          check_field("wheel_out", want.wheel, wheel_out_o);
          check_field("duty", want.duty, duty_o);
          check_field("direction", want.dir, direction_o);
          check_field("signed_drive", $signed(want.drive), $signed(signed_drive_o));
        end
      end
      if (!held && items_in >= HOLD_AT) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        stall_left = 0;
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("No beat moved for %0d cycles.", QUIET_LIMIT);
    $display("tb_wheel_pi_speed_drive: errors");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/wpsd_pkg.sv
hw/rtl/wheel_pi_speed_drive.sv
verif/tb_wheel_pi_speed_drive.sv
